@@ sv/bmsrf_pkg.sv @@
// ----------------------------------------------------------------------------
// bmsrf_pkg
// Shared types, constants and the crc helper for the request framer.
// ----------------------------------------------------------------------------
`default_nettype none

package bmsrf_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = 2;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [7:0]  TrailA  = 8'hAA;
  localparam logic [7:0]  TrailB  = 8'h55;

  localparam logic [7:0] HeadReset = 8'h7E;
  localparam logic [7:0] DevReset  = 8'hA1;

  localparam logic [7:0] RegHead = 8'd0;
  localparam logic [7:0] RegDev  = 8'd1;

  localparam logic CmdStart   = 1'b0;
  localparam logic CmdPayload = 1'b1;

  // one unit of work for the serializer
  typedef struct packed {
    logic        is_start;
    logic        close;    // trailer follows this job
    logic [7:0]  fc;
    logic [15:0] addr;
    logic [7:0]  len;
    logic [7:0]  data;
  } job_t;

  // byte-wide reflected crc-16 update
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ sv/bms_request_framer_crc16_unit.sv @@
// ----------------------------------------------------------------------------
// bms_request_framer_crc16_unit
// Battery-monitor request framer: header, payload, crc-16 and trailer bytes.
// ----------------------------------------------------------------------------
// Requests enter at up to one per cycle into a 4-entry job queue; the
// serializer behind it emits one frame byte per cycle while jobs are queued
// and the output is taken. A start request produces 6 bytes (10 when its
// length is zero), a payload request 1 byte (5 on the last one), so the
// sustained request rate is set by the serializer's byte count per frame.
// Payload requests with no open frame are taken and dropped. The crc covers
// the device address byte up to the last payload byte, updated as each is sent.
`default_nettype none

module bms_request_framer_crc16_unit
  import bmsrf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // function_code[7:0], register_address[23:8], payload_length[31:24],
  // payload_byte[39:32]
  input  wire logic [39:0] s_axis_tdata,
  // command[0]
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // frame_byte[7:0]
  output logic [7:0]       m_axis_tdata,
  output logic             m_axis_tlast
);

  logic [7:0] head_q, head_d;
  logic [7:0] dev_q, dev_d;
  logic       push, full, pop, q_valid;
  job_t       push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    head_d = head_q;
    dev_d  = dev_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegHead: head_d = cfg_data_i;
        RegDev:  dev_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= HeadReset;
      dev_q  <= DevReset;
    end else begin
      head_q <= head_d;
      dev_q  <= dev_d;
    end
  end

  bmsrf_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .req_valid_i        (s_axis_tvalid),
    .req_ready_o        (s_axis_tready),
    .command_i          (s_axis_tuser),
    .function_code_i    (s_axis_tdata[7:0]),
    .register_address_i (s_axis_tdata[23:8]),
    .payload_length_i   (s_axis_tdata[31:24]),
    .payload_byte_i     (s_axis_tdata[39:32]),
    .push_o             (push),
    .push_data_o        (push_data),
    .full_i             (full)
  );

  bmsrf_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  bmsrf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_byte_i (head_q),
    .dev_byte_i  (dev_q),
    .q_valid_i   (q_valid),
    .q_data_i    (pop_data),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_end_o   (m_axis_tlast)
  );

endmodule

`default_nettype wire

@@ sv/bmsrf_fifo.sv @@
// ----------------------------------------------------------------------------
// bmsrf_fifo
// Short job queue between the request front end and the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module bmsrf_fifo
  import bmsrf_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  job_t      push_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output job_t      pop_data_o
);

  job_t             mem_q [QDepth];
  logic [QAw-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QAw-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QAw:0]     count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == (QAw+1)'(QDepth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/bmsrf_front.sv @@
// ----------------------------------------------------------------------------
// bmsrf_front
// Takes requests, tracks the open frame and queues serializer jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module bmsrf_front
  import bmsrf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        req_valid_i,
  output logic             req_ready_o,
  input  wire logic        command_i,
  input  wire logic [7:0]  function_code_i,
  input  wire logic [15:0] register_address_i,
  input  wire logic [7:0]  payload_length_i,
  input  wire logic [7:0]  payload_byte_i,
  output logic             push_o,
  output job_t             push_data_o,
  input  wire logic        full_i
);

  logic       open_q, open_d;
  logic [7:0] remaining_q, remaining_d;
  logic       accept;

  assign req_ready_o = !full_i;
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    open_d      = open_q;
    remaining_d = remaining_q;
    push_o      = 1'b0;
    push_data_o = '{is_start: (command_i == CmdStart), close: 1'b0,
                    fc: function_code_i, addr: register_address_i,
                    len: payload_length_i, data: payload_byte_i};
    if (accept) begin
      if (command_i == CmdStart) begin
        // a new start abandons any open frame
        push_o            = 1'b1;
        push_data_o.close = (payload_length_i == 8'd0);
        open_d            = (payload_length_i != 8'd0);
        remaining_d       = payload_length_i;
      end else if (open_q) begin
        push_o            = 1'b1;
        push_data_o.close = (remaining_q == 8'd1);
        remaining_d       = remaining_q - 8'd1;
        open_d            = (remaining_q != 8'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      remaining_q <= '0;
    end else begin
      open_q      <= open_d;
      remaining_q <= remaining_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/bmsrf_back.sv @@
// ----------------------------------------------------------------------------
// bmsrf_back
// Serializes queued jobs into frame bytes, one per cycle unless stalled, with running crc.
// ----------------------------------------------------------------------------
`default_nettype none

module bmsrf_back
  import bmsrf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] head_byte_i,
  input  wire logic [7:0] dev_byte_i,
  input  wire logic       q_valid_i,
  input  job_t            q_data_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            out_end_o
);

  localparam logic [3:0] StHead = 4'd0;
  localparam logic [3:0] StDev  = 4'd1;
  localparam logic [3:0] StFc   = 4'd2;
  localparam logic [3:0] StAlo  = 4'd3;
  localparam logic [3:0] StAhi  = 4'd4;
  localparam logic [3:0] StLen  = 4'd5;
  localparam logic [3:0] StPay  = 4'd6;
  localparam logic [3:0] StCrcH = 4'd7;
  localparam logic [3:0] StCrcL = 4'd8;
  localparam logic [3:0] StTa   = 4'd9;
  localparam logic [3:0] StTb   = 4'd10;

  job_t        job_q, job_d;
  logic        busy_q, busy_d;
  logic [3:0]  step_q, step_d;
  logic [15:0] crc_q, crc_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_end_q, out_end_d;

  logic        adv;
  logic        last_step;
  logic [3:0]  next_step;
  logic [7:0]  cur_byte;
  logic        covered;

  assign adv = busy_q && (!out_valid_q || out_ready_i);

  always_comb begin
    cur_byte  = 8'h00;
    next_step = step_q;
    last_step = 1'b0;
    case (step_q)
      StHead: begin cur_byte = head_byte_i; next_step = StDev; end
      StDev:  begin cur_byte = dev_byte_i; next_step = StFc; end
      StFc:   begin cur_byte = job_q.fc; next_step = StAlo; end
      StAlo:  begin cur_byte = job_q.addr[7:0]; next_step = StAhi; end
      StAhi:  begin cur_byte = job_q.addr[15:8]; next_step = StLen; end
      StLen:  begin
        cur_byte  = job_q.len;
        next_step = StCrcH;
        last_step = !job_q.close;
      end
      StPay:  begin
        cur_byte  = job_q.data;
        next_step = StCrcH;
        last_step = !job_q.close;
      end
      StCrcH: begin cur_byte = crc_q[15:8]; next_step = StCrcL; end
      StCrcL: begin cur_byte = crc_q[7:0]; next_step = StTa; end
      StTa:   begin cur_byte = TrailA; next_step = StTb; end
      StTb:   begin cur_byte = TrailB; last_step = 1'b1; end
      default: begin cur_byte = 8'h00; last_step = 1'b1; end
    endcase
    covered = (step_q inside {StDev, StFc, StAlo, StAhi, StLen, StPay});
  end

  always_comb begin
    pop_o       = q_valid_i && (!busy_q || (adv && last_step));
    job_d       = job_q;
    busy_d      = busy_q;
    step_d      = step_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_end_d   = out_end_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (adv) begin
      out_valid_d = 1'b1;
      out_byte_d  = cur_byte;
      out_end_d   = (step_q == StTb);
      step_d      = next_step;
      if (step_q == StHead || step_q == StTb) begin
        crc_d = CrcInit;
      end else if (covered) begin
        crc_d = crc16_byte(crc_q, cur_byte);
      end
      if (last_step) begin
        busy_d = 1'b0;
      end
    end

    if (pop_o) begin
      job_d  = q_data_i;
      busy_d = 1'b1;
      step_d = q_data_i.is_start ? StHead : StPay;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= StHead;
      crc_q       <= CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    out_byte_q <= out_byte_d;
    out_end_q  <= out_end_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_end_o   = out_end_q;

`ifndef SYNTHESIS
  a_end_is_trailer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_end_q |-> out_byte_q == TrailB)
    else $error("frame end not on trailer byte");

  a_ta_then_tb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && step_q == StTa |=> busy_q && step_q == StTb)
    else $error("trailer sequence broken");

  a_pop_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> q_valid_i)
    else $error("pop from empty queue");

  a_pop_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && busy_q |-> adv && last_step)
    else $error("job loaded over a running job");
`endif

endmodule

`default_nettype wire
